>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked assertions on clk, gated off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while rst_n is low.
`define SP2PWM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication.
`define SP2PWM_ASSERT_IMPL(label, ante, cons, msg) \
    `SP2PWM_ASSERT(label, (ante) |-> (cons), msg)

`endif

>>> src/sp2pwm_pkg.sv
// ----------------------------------------------------------------------------
// sp2pwm_pkg
// Types and fixed constants shared by the servo packet to PWM modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sp2pwm_pkg;

    localparam int CHANNEL_COUNT    = 8;
    localparam int CH_W             = 3;
    localparam int BYTE_W           = 8;
    localparam int ANGLE_W          = 8;
    localparam int OFFSET_W         = 16;
    localparam int PULSE_W          = 12;
    localparam int COUNT_W          = 10;
    localparam int CFG_INDEX_W      = 3;
    localparam int MIN_PACKET_BYTES = 18;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [BYTE_W-1:0]  SYNC_FIRST   = 8'hAA;
    localparam logic [BYTE_W-1:0]  SYNC_SECOND  = 8'h55;
    localparam logic [ANGLE_W-1:0] ANGLE_MAX    = 8'd180;
    localparam logic [PULSE_W-1:0] PULSE_MIN    = 12'd500;
    localparam logic [PULSE_W-1:0] PULSE_MAX    = 12'd2500;
    localparam logic [PULSE_W-1:0] PULSE_MIRROR = 12'd3000;

    // angle * 2000 / 180 as (angle * round_up(2^16 * 100 / 9)) >> 16, exact for angle <= 180
    localparam int ANGLE_SCALE_W = 20;
    localparam int ANGLE_SHIFT   = 16;
    localparam logic [ANGLE_SCALE_W-1:0] ANGLE_SCALE = 20'd728178;

    // pulse * 4096 / 20000 as (pulse * round_up(2^28 * 128 / 625)) >> 28, exact for pulse <= 2500
    localparam int COUNT_SCALE_W = 26;
    localparam int COUNT_SHIFT   = 28;
    localparam logic [COUNT_SCALE_W-1:0] COUNT_SCALE = 26'd54975582;

    typedef logic [ANGLE_W-1:0]  angle_t;
    typedef logic [OFFSET_W-1:0] offset_t;
    typedef angle_t  [CHANNEL_COUNT-1:0] angle_set_t;
    typedef offset_t [CHANNEL_COUNT-1:0] offset_set_t;

    // One accepted packet: its eight clamped angles.
    typedef struct packed {
        logic       valid;
        angle_set_t angles;
    } pkt_slot_t;

endpackage

`default_nettype wire

>>> src/sp2pwm_front.sv
// ----------------------------------------------------------------------------
// sp2pwm_front
// Byte parser: checks sync and length, assembles and clamps angles, and
// pushes the angle set of each good packet into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sp2pwm_front #(
    parameter int MAX_PACKET_BYTES = 128
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [sp2pwm_pkg::BYTE_W-1:0]     rx_byte,
    input  wire logic                              end_of_packet,
    input  wire logic                              queue_full,
    output sp2pwm_pkg::pkt_slot_t                  push
);

    localparam int POS_W = $clog2(MAX_PACKET_BYTES + 2);
    localparam logic [POS_W-1:0] POS_SAT = POS_W'(MAX_PACKET_BYTES + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PACKET_BYTES);
    localparam logic [POS_W-1:0] POS_MIN = POS_W'(sp2pwm_pkg::MIN_PACKET_BYTES);

    logic [POS_W-1:0]                   pos_reg, pos_next;
    logic                               sync_reg, sync_next;
    sp2pwm_pkg::angle_t                 low_reg, low_next;
    sp2pwm_pkg::angle_set_t             angle_reg, angle_next;

    logic                               take;
    logic                               is_angle_byte;
    logic [POS_W-1:0]                   slot_wide;
    logic [sp2pwm_pkg::CH_W-1:0]        slot;
    sp2pwm_pkg::angle_t                 angle_clamped;
    logic                               sync_upd;
    logic [POS_W-1:0]                   length;
    logic                               packet_ok;

    assign in_stall = queue_full;
    assign take     = in_valid && !queue_full;

    assign is_angle_byte = (pos_reg >= POS_W'(2)) && (pos_reg < POS_MIN);
    assign slot_wide     = pos_reg - POS_W'(2);
    assign slot          = slot_wide[sp2pwm_pkg::CH_W:1];

    // Any nonzero high byte puts the angle above the limit.
    assign angle_clamped = ((rx_byte != '0) || (low_reg > sp2pwm_pkg::ANGLE_MAX))
                           ? sp2pwm_pkg::ANGLE_MAX : low_reg;

    assign length    = (pos_reg == POS_SAT) ? pos_reg : pos_reg + POS_W'(1);
    assign packet_ok = sync_upd && (length >= POS_MIN) && (length <= POS_MAX);

    always_comb
    begin
        priority if (pos_reg == POS_W'(0))
        begin
            sync_upd = (rx_byte == sp2pwm_pkg::SYNC_FIRST);
        end
        else if (pos_reg == POS_W'(1))
        begin
            sync_upd = sync_reg && (rx_byte == sp2pwm_pkg::SYNC_SECOND);
        end
        else
        begin
            sync_upd = sync_reg;
        end
    end

    always_comb
    begin
        angle_next = angle_reg;
        low_next   = low_reg;
        pos_next   = pos_reg;
        sync_next  = sync_reg;
        if (is_angle_byte && pos_reg[0])
        begin
            angle_next[slot] = angle_clamped;
        end
        if (is_angle_byte && !pos_reg[0])
        begin
            low_next = rx_byte;
        end
        if (take)
        begin
            if (end_of_packet)
            begin
                pos_next  = '0;
                sync_next = 1'b1;
                low_next  = '0;
            end
            else
            begin
                pos_next  = length;
                sync_next = sync_upd;
            end
        end
        else
        begin
            angle_next = angle_reg;
            low_next   = low_reg;
        end
    end

    // Include the angle written by the final byte itself.
    assign push.valid  = take && end_of_packet && packet_ok;
    assign push.angles = angle_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            sync_reg <= 1'b1;
            low_reg  <= '0;
            for (int i = 0; i < sp2pwm_pkg::CHANNEL_COUNT; i++)
            begin
                angle_reg[i] <= sp2pwm_pkg::ANGLE_W'(90);
            end
        end
        else
        begin
            pos_reg   <= pos_next;
            sync_reg  <= sync_next;
            low_reg   <= low_next;
            angle_reg <= angle_next;
        end
    end

endmodule

`default_nettype wire

>>> src/sp2pwm_queue.sv
// ----------------------------------------------------------------------------
// sp2pwm_queue
// Short queue of accepted angle sets between the parser and the PWM
// pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module sp2pwm_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire sp2pwm_pkg::pkt_slot_t push,
    input  wire logic                  pop,
    output logic                       full,
    output sp2pwm_pkg::pkt_slot_t      head
);

    localparam int DEPTH = sp2pwm_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sp2pwm_pkg::angle_set_t entry_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   do_push, do_pop;

    assign full        = (count_reg == CNT_W'(DEPTH));
    assign head.valid  = (count_reg != '0);
    assign head.angles = entry_reg[rd_ptr_reg];

    assign do_push = push.valid && !full;
    assign do_pop  = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.angles;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> src/sp2pwm_back.sv
// ----------------------------------------------------------------------------
// sp2pwm_back
// PWM pipeline: walks channels 0 to 7 of the queue head and turns each
// angle into a count over three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module sp2pwm_back (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire sp2pwm_pkg::pkt_slot_t                 head,
    output logic                                       pop,
    input  wire sp2pwm_pkg::offset_set_t               offsets,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic [sp2pwm_pkg::CH_W-1:0]                channel,
    output logic [sp2pwm_pkg::COUNT_W-1:0]             pwm_count,
    output logic                                       last_of_run
);

    localparam int CH_W    = sp2pwm_pkg::CH_W;
    localparam int PULSE_W = sp2pwm_pkg::PULSE_W;
    localparam int OFF_W   = sp2pwm_pkg::OFFSET_W;
    localparam int BPROD_W = sp2pwm_pkg::ANGLE_W + sp2pwm_pkg::ANGLE_SCALE_W;
    localparam int CPROD_W = PULSE_W + sp2pwm_pkg::COUNT_SCALE_W;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(sp2pwm_pkg::CHANNEL_COUNT - 1);

    logic                       advance;
    logic                       issue;
    logic [CH_W-1:0]            ch_cnt_reg;

    logic                       v1_reg;
    logic [CH_W-1:0]            ch1_reg;
    logic [PULSE_W-1:0]         base1_reg;
    sp2pwm_pkg::offset_t        off1_reg;

    logic                       v2_reg;
    logic [CH_W-1:0]            ch2_reg;
    logic [PULSE_W-1:0]         pulse2_reg;

    logic                       out_valid_reg;
    logic [CH_W-1:0]            channel_reg;
    logic [sp2pwm_pkg::COUNT_W-1:0] count_reg;
    logic                       last_reg;

    logic [BPROD_W-1:0]         base_prod;
    logic [PULSE_W-1:0]         base_pulse;
    logic [OFF_W-1:0]           pulse_sum;
    logic [PULSE_W-1:0]         pulse_clamped;
    logic [PULSE_W-1:0]         pulse_final;
    logic [CPROD_W-1:0]         count_prod;

    // Whole pipe moves when the output register is free or being taken.
    assign advance = !out_valid_reg || !out_stall;
    assign issue   = head.valid && advance;
    assign pop     = issue && (ch_cnt_reg == LAST_CH);

    // Stage 1: base pulse from angle
    assign base_prod  = BPROD_W'(head.angles[ch_cnt_reg]) * BPROD_W'(sp2pwm_pkg::ANGLE_SCALE);
    assign base_pulse = sp2pwm_pkg::PULSE_MIN
                      + base_prod[BPROD_W-1:sp2pwm_pkg::ANGLE_SHIFT];

    // Stage 2: offset with 16-bit wrap, clamp, mirror upper channels
    assign pulse_sum = OFF_W'(base1_reg) + off1_reg;

    always_comb
    begin
        priority if (pulse_sum < OFF_W'(sp2pwm_pkg::PULSE_MIN))
        begin
            pulse_clamped = sp2pwm_pkg::PULSE_MIN;
        end
        else if (pulse_sum > OFF_W'(sp2pwm_pkg::PULSE_MAX))
        begin
            pulse_clamped = sp2pwm_pkg::PULSE_MAX;
        end
        else
        begin
            pulse_clamped = pulse_sum[PULSE_W-1:0];
        end
    end

    assign pulse_final = ch1_reg[CH_W-1] ? (sp2pwm_pkg::PULSE_MIRROR - pulse_clamped)
                                         : pulse_clamped;

    // Stage 3: scale pulse to a count out of 4096
    assign count_prod = CPROD_W'(pulse2_reg) * CPROD_W'(sp2pwm_pkg::COUNT_SCALE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_cnt_reg    <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (issue)
            begin
                ch_cnt_reg <= ch_cnt_reg + CH_W'(1);
            end
            v1_reg        <= issue;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ch1_reg     <= ch_cnt_reg;
            base1_reg   <= base_pulse;
            off1_reg    <= offsets[ch_cnt_reg];
            ch2_reg     <= ch1_reg;
            pulse2_reg  <= pulse_final;
            channel_reg <= ch2_reg;
            count_reg   <= count_prod[CPROD_W-1:sp2pwm_pkg::COUNT_SHIFT];
            last_reg    <= (ch2_reg == LAST_CH);
        end
    end

    assign out_valid   = out_valid_reg;
    assign channel     = channel_reg;
    assign pwm_count   = count_reg;
    assign last_of_run = last_reg;

endmodule

`default_nettype wire

>>> src/servo_packet_to_pwm.sv
// Servo packet to PWM converter.
// Input channel: one packet byte per item (rx_byte), end_of_packet set on the
// final byte. A packet is AA 55 followed by eight little-endian 16-bit angles;
// it is good when both sync bytes match and its length is 18 to
// MAX_PACKET_BYTES bytes. Extra bytes past the angles are only counted.
// Output channel: for each good packet, eight items, channel 0 to 7, each with
// a 10-bit on-time count out of 4096; last_of_run marks channel 7.
// Config port: cfg_write stores cfg_data into offset register cfg_index; write
// only while the block is idle.
// Throughput: one byte per cycle in while in_stall is low; one count per cycle
// out while out_stall is low. Each angle passes stage 1 angle scale, stage 2
// offset and clamp, and stage 3 count scale. A two-entry packet queue lets the
// parser take the next packet while counts drain; in_stall rises only when that
// queue is full.
// Reset: offsets clear to zero, staged angles to 90, the queue and pipeline
// empty. out_stall with out_valid high freezes the whole pipeline and output.
// ----------------------------------------------------------------------------
// servo_packet_to_pwm
// Top level: offset registers and the parser, queue and PWM pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_packet_to_pwm #(
    parameter int MAX_PACKET_BYTES = 128
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic [sp2pwm_pkg::BYTE_W-1:0]         rx_byte,
    input  wire logic                                  end_of_packet,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic [sp2pwm_pkg::CH_W-1:0]                channel,
    output logic [sp2pwm_pkg::COUNT_W-1:0]             pwm_count,
    output logic                                       last_of_run,
    input  wire logic                                  cfg_write,
    input  wire logic [sp2pwm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [sp2pwm_pkg::OFFSET_W-1:0]       cfg_data
);

    sp2pwm_pkg::offset_set_t offset_reg;
    sp2pwm_pkg::pkt_slot_t   push;
    sp2pwm_pkg::pkt_slot_t   head;
    logic                    queue_full;
    logic                    pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
        end
        else if (cfg_write)
        begin
            offset_reg[cfg_index] <= cfg_data;
        end
    end

    sp2pwm_front #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .end_of_packet (end_of_packet),
        .queue_full    (queue_full),
        .push          (push)
    );

    sp2pwm_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (queue_full),
        .head  (head)
    );

    sp2pwm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (pop),
        .offsets     (offset_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .channel     (channel),
        .pwm_count   (pwm_count),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire

>>> src/sp2pwm_checker.sv
// ----------------------------------------------------------------------------
// sp2pwm_checker
// Port-level checks on the servo packet to PWM block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sp2pwm_checker (
    input wire logic                                  clk,
    input wire logic                                  rst_n,
    input wire logic                                  out_valid,
    input wire logic                                  out_stall,
    input wire logic [sp2pwm_pkg::CH_W-1:0]           channel,
    input wire logic [sp2pwm_pkg::COUNT_W-1:0]        pwm_count,
    input wire logic                                  last_of_run
);

    localparam int CH_W = sp2pwm_pkg::CH_W;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(sp2pwm_pkg::CHANNEL_COUNT - 1);
    localparam logic [sp2pwm_pkg::COUNT_W-1:0] COUNT_LO = 10'd102;
    localparam logic [sp2pwm_pkg::COUNT_W-1:0] COUNT_HI = 10'd512;

    logic [CH_W-1:0] exp_ch_reg;

    // Track the channel the next item must carry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_ch_reg <= '0;
        end
        else if (out_valid && !out_stall)
        begin
            exp_ch_reg <= channel + CH_W'(1);
        end
    end

    `SP2PWM_ASSERT(a_out_hold,
        out_valid && out_stall |=> out_valid && $stable(channel)
            && $stable(pwm_count) && $stable(last_of_run),
        "stalled result changed")
    `SP2PWM_ASSERT_IMPL(a_channel_order, out_valid, channel == exp_ch_reg,
        "channel out of order")
    `SP2PWM_ASSERT_IMPL(a_last_mark, out_valid, last_of_run == (channel == LAST_CH),
        "last_of_run not on channel 7")
    `SP2PWM_ASSERT_IMPL(a_count_range, out_valid,
        pwm_count >= COUNT_LO && pwm_count <= COUNT_HI,
        "count outside clamp range")

endmodule

bind servo_packet_to_pwm sp2pwm_checker u_checker (.*);

`default_nettype wire
